// ===== rtl/wvcl_pkg.sv =====
// wvcl_pkg: shared widths, register indexes and reset values of the
// walk velocity command limiter. No dependencies.
package wvcl_pkg;

  localparam int unsigned CMD_W      = 16;
  localparam int unsigned LIM_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic signed [CMD_W-1:0] vel_t;
  typedef logic [LIM_W-1:0]        lim_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_MIN,
    REG_FWD_MAX,
    REG_SIDE_MIN,
    REG_SIDE_MAX,
    REG_TURN_MIN,
    REG_TURN_MAX,
    REG_TURN_SLOWDOWN
  } cfg_reg_e;

  localparam vel_t MIN_RST      = -16'sd4096;
  localparam lim_t MAX_RST      = 15'd4096;
  localparam lim_t SLOWDOWN_RST = 15'd8192;

endpackage

// ===== rtl/wvcl_intf.sv =====
// wvcl channel interfaces: command input, velocity output, register writes.
// Depends on wvcl_pkg.
interface wvcl_cmd_if;
  import wvcl_pkg::*;
  logic valid;
  logic ready;
  vel_t cmd_fwd;
  vel_t cmd_side;
  vel_t cmd_turn;
  modport source (output valid, output cmd_fwd, output cmd_side, output cmd_turn,
                  input ready);
  modport sink   (input valid, input cmd_fwd, input cmd_side, input cmd_turn,
                  output ready);
endinterface

interface wvcl_vel_if;
  import wvcl_pkg::*;
  logic valid;
  logic ready;
  vel_t vel_fwd;
  vel_t vel_side;
  vel_t vel_turn;
  modport source (output valid, output vel_fwd, output vel_side, output vel_turn,
                  input ready);
  modport sink   (input valid, input vel_fwd, input vel_side, input vel_turn,
                  output ready);
endinterface

interface wvcl_cfg_if;
  import wvcl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/walk_velocity_command_limiter.sv =====
// walk_velocity_command_limiter: pipelined per-axis scaling, turn slow-down
// cap, planar magnitude and rescale. Depends on wvcl_pkg and wvcl_intf.
//
//   port    dir  handshake      payload
//   cmd_i   in   valid/ready    cmd_fwd, cmd_side, cmd_turn
//   vel_o   out  valid/ready    vel_fwd, vel_side, vel_turn
//   cfg_i   in   valid/ready    index, data (ready always high)
//
// one item per cycle while the output is not stalled; the pipeline depth is
// set by the slow-down divider, one quotient bit per stage (17 + FRAC_BITS
// stages, the square root runs alongside) and the 16-stage rescale divider.
// reset loads the register defaults and empties the pipeline.
// a full stage holds while the stage after it is full and stalled; empty
// stages close up, so input is taken while a result waits at the output.
module walk_velocity_command_limiter #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wvcl_cmd_if.sink   cmd_i,
  wvcl_vel_if.source vel_o,
  wvcl_cfg_if.sink   cfg_i
);
  import wvcl_pkg::*;

  localparam int unsigned DQ_W   = 17 + FRAC_BITS;
  localparam int unsigned VF_W   = DQ_W + 1;
  localparam int unsigned PR_W   = VF_W + 16;
  localparam int unsigned LOOP_N = DQ_W;
  localparam int unsigned SQRT_N = 16;
  localparam int unsigned DIV_N  = 16;

  localparam int unsigned S_A   = 0;
  localparam int unsigned S_B   = 1;
  localparam int unsigned S_C   = 2;
  localparam int unsigned S_D   = 3;
  localparam int unsigned S_LP0 = 4;
  localparam int unsigned S_E   = S_LP0 + LOOP_N;
  localparam int unsigned S_G   = S_E + 1;
  localparam int unsigned S_H   = S_G + 1;
  localparam int unsigned S_DV0 = S_H + 1;
  localparam int unsigned S_OUT = S_DV0 + DIV_N;
  localparam int unsigned NS    = S_OUT + 1;

  typedef struct packed {
    vel_t x;
    vel_t y;
    vel_t t;
  } axes_t;

  typedef struct packed {
    axes_t           ax;
    logic [DQ_W-1:0] dq;
    logic [15:0]     drem;
    logic [31:0]     rad;
    logic [17:0]     srem;
    logic [15:0]     root;
  } loop_t;

  typedef struct packed {
    axes_t       ax;
    logic [15:0] mag;
    logic        capneg;
    logic        resc;
    logic        mz;
    logic        satx;
    logic        saty;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [14:0] qx;
    logic [14:0] qy;
  } div_t;

  function automatic vel_t clamp_f(logic signed [33:0] v, vel_t lo, lim_t hi);
    logic signed [33:0] r;
    r = v;
    if (r < 34'(lo)) r = 34'(lo);
    if (r > signed'({19'b0, hi})) r = signed'({19'b0, hi});
    return r[15:0];
  endfunction

  function automatic logic signed [32:0] scale_f(vel_t c, vel_t lo, lim_t hi);
    logic signed [16:0] g;
    g = (c > 0) ? signed'({2'b00, hi}) : -(17'(lo));
    return 33'(c) * 33'(g);
  endfunction

  function automatic vel_t planar_f(vel_t v, logic sat, logic [14:0] q, logic capneg,
                                    logic resc, logic mz, vel_t lo, lim_t hi);
    logic signed [33:0] s;
    s = sat ? 34'sd32768 : signed'({19'b0, q});
    if (v[15] != capneg) s = -s;
    if (mz) s = '0;
    else if (!resc) s = 34'(v);
    return clamp_f(s, lo, hi);
  endfunction

  // configuration registers
  vel_t fwd_min_q, side_min_q, turn_min_q;
  lim_t fwd_max_q, side_max_q, turn_max_q, slowdown_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_min_q  <= MIN_RST;
      side_min_q <= MIN_RST;
      turn_min_q <= MIN_RST;
      fwd_max_q  <= MAX_RST;
      side_max_q <= MAX_RST;
      turn_max_q <= MAX_RST;
      slowdown_q <= SLOWDOWN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FWD_MIN:       fwd_min_q  <= cfg_i.data;
        REG_FWD_MAX:       fwd_max_q  <= cfg_i.data[LIM_W-1:0];
        REG_SIDE_MIN:      side_min_q <= cfg_i.data;
        REG_SIDE_MAX:      side_max_q <= cfg_i.data[LIM_W-1:0];
        REG_TURN_MIN:      turn_min_q <= cfg_i.data;
        REG_TURN_MAX:      turn_max_q <= cfg_i.data[LIM_W-1:0];
        REG_TURN_SLOWDOWN: slowdown_q <= cfg_i.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  lim_t div_w;
  assign div_w = (slowdown_q == '0) ? lim_t'(1) : slowdown_q;

  // valid bits and ready chain
  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  assign rdy[NS]     = vel_o.ready;
  assign vin         = {v_q[NS-2:0], cmd_i.valid};
  assign cmd_i.ready = rdy[S_A];

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  // stages A to D: capture, scale, clamp, squares
  axes_t              a0_q, a2_q, a3_q;
  logic signed [32:0] px1_q, py1_q, pt1_q;
  logic [31:0]        sq3_q;
  logic [16:0]        at3_q;
  logic [31:0]        sq_d;
  logic [16:0]        at_d;

  assign sq_d = 32'(32'(a2_q.x) * 32'(a2_q.x)) + 32'(32'(a2_q.y) * 32'(a2_q.y));
  assign at_d = a2_q.t[15] ? 17'(-(17'(a2_q.t))) : 17'(a2_q.t);

  always_ff @(posedge clk_i) begin
    if (rdy[S_A]) a0_q <= '{x: cmd_i.cmd_fwd, y: cmd_i.cmd_side, t: cmd_i.cmd_turn};
    if (rdy[S_B]) begin
      px1_q <= scale_f(a0_q.x, fwd_min_q, fwd_max_q);
      py1_q <= scale_f(a0_q.y, side_min_q, side_max_q);
      pt1_q <= scale_f(a0_q.t, turn_min_q, turn_max_q);
    end
    if (rdy[S_C]) begin
      a2_q.x <= clamp_f(34'(px1_q >>> FRAC_BITS), fwd_min_q, fwd_max_q);
      a2_q.y <= clamp_f(34'(py1_q >>> FRAC_BITS), side_min_q, side_max_q);
      a2_q.t <= clamp_f(34'(pt1_q >>> FRAC_BITS), turn_min_q, turn_max_q);
    end
    if (rdy[S_D]) begin
      a3_q  <= a2_q;
      sq3_q <= sq_d;
      at3_q <= at_d;
    end
  end

  // slow-down divider and square root, one step per stage
  loop_t lp_in [LOOP_N];
  loop_t lp_d  [LOOP_N];
  loop_t lp_q  [LOOP_N];

  assign lp_in[0] = '{ax: a3_q, dq: {at3_q, {FRAC_BITS{1'b0}}}, drem: '0,
                      rad: sq3_q, srem: '0, root: '0};

  for (genvar i = 0; i < LOOP_N; i++) begin : g_loop
    if (i > 0) begin : g_link
      assign lp_in[i] = lp_q[i-1];
    end
    logic [15:0] r2;
    logic        qb;
    logic [17:0] sr2;
    logic [17:0] trial;
    logic        sb;
    assign r2    = {lp_in[i].drem[14:0], lp_in[i].dq[DQ_W-1]};
    assign qb    = (r2 >= {1'b0, div_w});
    assign sr2   = {lp_in[i].srem[15:0], lp_in[i].rad[31:30]};
    assign trial = {lp_in[i].root, 2'b01};
    assign sb    = (sr2 >= trial);
    always_comb begin
      lp_d[i]      = lp_in[i];
      lp_d[i].dq   = {lp_in[i].dq[DQ_W-2:0], qb};
      lp_d[i].drem = qb ? (r2 - {1'b0, div_w}) : r2;
      if (i < SQRT_N) begin
        lp_d[i].srem = sb ? (sr2 - trial) : sr2;
        lp_d[i].root = {lp_in[i].root[14:0], sb};
        lp_d[i].rad  = {lp_in[i].rad[29:0], 2'b00};
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[S_LP0+i]) lp_q[i] <= lp_d[i];
    end
  end

  // stage E: speed factor times forward maximum
  axes_t                   ae_q;
  logic [15:0]             mage_q;
  logic signed [PR_W-1:0]  prod_q;
  logic signed [VF_W-1:0]  vf_d;

  assign vf_d = signed'(VF_W'(1) << FRAC_BITS) - signed'(VF_W'(lp_q[LOOP_N-1].dq));

  always_ff @(posedge clk_i) begin
    if (rdy[S_E]) begin
      ae_q   <= lp_q[LOOP_N-1].ax;
      mage_q <= lp_q[LOOP_N-1].root;
      prod_q <= PR_W'(signed'({1'b0, fwd_max_q})) * PR_W'(vf_d);
    end
  end

  // stage G: cap, its magnitude (saturated), rescale decision
  logic signed [PR_W-1:0] cap_d;
  logic [PR_W-1:0]        acap_d;
  axes_t                  ag_q;
  logic [15:0]            magg_q;
  logic [31:0]            acg_q;
  logic                   capneg_g_q, resc_g_q, mz_g_q;

  assign cap_d  = prod_q >>> FRAC_BITS;
  assign acap_d = cap_d[PR_W-1] ? PR_W'(-cap_d) : PR_W'(cap_d);

  always_ff @(posedge clk_i) begin
    if (rdy[S_G]) begin
      ag_q       <= ae_q;
      magg_q     <= mage_q;
      // beyond 2^31 every nonzero axis lands on a clamp limit anyway
      acg_q      <= (acap_d[PR_W-1:31] != '0) ? 32'h8000_0000 : acap_d[31:0];
      capneg_g_q <= cap_d[PR_W-1];
      resc_g_q   <= (cap_d < signed'(PR_W'({1'b0, mage_q})));
      mz_g_q     <= (mage_q == '0);
    end
  end

  // stage H: |v| * |cap|
  axes_t       ah_q;
  logic [15:0] magh_q;
  logic [47:0] pxh_q, pyh_q;
  logic        capneg_h_q, resc_h_q, mz_h_q;
  logic [15:0] absx_d, absy_d;

  assign absx_d = ag_q.x[15] ? 16'(-ag_q.x) : 16'(ag_q.x);
  assign absy_d = ag_q.y[15] ? 16'(-ag_q.y) : 16'(ag_q.y);

  always_ff @(posedge clk_i) begin
    if (rdy[S_H]) begin
      ah_q       <= ag_q;
      magh_q     <= magg_q;
      pxh_q      <= 48'(absx_d) * 48'(acg_q);
      pyh_q      <= 48'(absy_d) * 48'(acg_q);
      capneg_h_q <= capneg_g_q;
      resc_h_q   <= resc_g_q;
      mz_h_q     <= mz_g_q;
    end
  end

  // rescale dividers: 15 quotient bits, saturate when the quotient reaches 2^15
  div_t dv_in [DIV_N];
  div_t dv_q  [DIV_N];
  logic [47:0] magsh_d;

  assign magsh_d  = 48'({magh_q, 15'b0});
  assign dv_in[0] = '{ax: ah_q, mag: magh_q, capneg: capneg_h_q, resc: resc_h_q,
                      mz: mz_h_q, satx: (pxh_q >= magsh_d), saty: (pyh_q >= magsh_d),
                      rx: pxh_q[30:15], ry: pyh_q[30:15],
                      qx: pxh_q[14:0], qy: pyh_q[14:0]};

  for (genvar k = 1; k < DIV_N; k++) begin : g_div
    logic [16:0] rx2, ry2;
    logic        bx, by;
    assign rx2 = {dv_q[k-1].rx, dv_q[k-1].qx[14]};
    assign ry2 = {dv_q[k-1].ry, dv_q[k-1].qy[14]};
    assign bx  = (rx2 >= {1'b0, dv_q[k-1].mag});
    assign by  = (ry2 >= {1'b0, dv_q[k-1].mag});
    always_comb begin
      dv_in[k]    = dv_q[k-1];
      dv_in[k].rx = bx ? 16'(rx2 - {1'b0, dv_q[k-1].mag}) : rx2[15:0];
      dv_in[k].ry = by ? 16'(ry2 - {1'b0, dv_q[k-1].mag}) : ry2[15:0];
      dv_in[k].qx = {dv_q[k-1].qx[13:0], bx};
      dv_in[k].qy = {dv_q[k-1].qy[13:0], by};
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_dreg
    always_ff @(posedge clk_i) begin
      if (rdy[S_DV0+k]) dv_q[k] <= dv_in[k];
    end
  end

  // output register: pick planar result, final clamp
  axes_t out_q;
  div_t  df;

  assign df = dv_q[DIV_N-1];

  always_ff @(posedge clk_i) begin
    if (rdy[S_OUT]) begin
      out_q.x <= planar_f(df.ax.x, df.satx, df.qx, df.capneg, df.resc, df.mz,
                          fwd_min_q, fwd_max_q);
      out_q.y <= planar_f(df.ax.y, df.saty, df.qy, df.capneg, df.resc, df.mz,
                          side_min_q, side_max_q);
      out_q.t <= df.ax.t;
    end
  end

  assign vel_o.valid    = v_q[S_OUT];
  assign vel_o.vel_fwd  = out_q.x;
  assign vel_o.vel_side = out_q.y;
  assign vel_o.vel_turn = out_q.t;

  // divider precondition: starting remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_DV0] && !dv_q[0].mz && !dv_q[0].satx |-> dv_q[0].rx < dv_q[0].mag)
    else $error("rescale divider remainder not below magnitude");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> v_q[S_A])
    else $error("accepted item not captured");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_OUT] && !vel_o.ready |=> v_q[S_OUT])
    else $error("stalled result dropped");

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench of walk_velocity_command_limiter.
// Depends on wvcl_pkg, the wvcl channel interfaces and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import wvcl_pkg::*;

  localparam int FRAC = 12;
  localparam int LATENCY = FRAC + 41;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    vel_t fwd;
    vel_t side;
    vel_t turn;
  } vel3_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   n_errors = 0;
  longint cycle_cnt = 0;

  wvcl_cmd_if cmd_if ();
  wvcl_vel_if vel_if ();
  wvcl_cfg_if cfg_if ();

  walk_velocity_command_limiter #(.FRAC_BITS(FRAC)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .vel_o  (vel_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always #5 clk_i = ~clk_i;

  // limiter settings as the testbench believes them
  longint lim_fwd_min, lim_fwd_max, lim_side_min, lim_side_max;
  longint lim_turn_min, lim_turn_max, lim_slowdown;
  vel3_t  vel_expected[$];
  bit     sink_stall_en = 1'b1;

  function automatic longint floor_shift(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint int_sqrt(longint s);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint shrink(longint v, longint cap, longint mag);
    longint q;
    q = ((v < 0 ? -v : v) * (cap < 0 ? -cap : cap)) / mag;
    return ((v < 0) != (cap < 0)) ? -q : q;
  endfunction

  function automatic vel3_t limit_velocity(vel_t cf, vel_t cs, vel_t ct);
    longint x, y, t, at, dv, vf, cap, mag;
    vel3_t r;
    x = cf; y = cs; t = ct;
    x = clip(floor_shift(x * (x > 0 ? lim_fwd_max : -lim_fwd_min)), lim_fwd_min, lim_fwd_max);
    y = clip(floor_shift(y * (y > 0 ? lim_side_max : -lim_side_min)),
             lim_side_min, lim_side_max);
    t = clip(floor_shift(t * (t > 0 ? lim_turn_max : -lim_turn_min)),
             lim_turn_min, lim_turn_max);
    at = t < 0 ? -t : t;
    dv = lim_slowdown == 0 ? 1 : lim_slowdown;
    vf = (64'sd1 <<< FRAC) - ((at <<< FRAC) / dv);
    cap = floor_shift(lim_fwd_max * vf);
    mag = int_sqrt(x * x + y * y);
    if (mag == 0) begin
      x = 0;
      y = 0;
    end else if (cap < mag) begin
      x = shrink(x, cap, mag);
      y = shrink(y, cap, mag);
    end
    r.fwd  = vel_t'(clip(x, lim_fwd_min, lim_fwd_max));
    r.side = vel_t'(clip(y, lim_side_min, lim_side_max));
    r.turn = vel_t'(clip(t, lim_turn_min, lim_turn_max));
    return r;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_FWD_MIN:  lim_fwd_min  = $signed(val);
      REG_FWD_MAX:  lim_fwd_max  = val[14:0];
      REG_SIDE_MIN: lim_side_min = $signed(val);
      REG_SIDE_MAX: lim_side_max = val[14:0];
      REG_TURN_MIN: lim_turn_min = $signed(val);
      REG_TURN_MAX: lim_turn_max = val[14:0];
      default:      lim_slowdown = val[14:0];
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_limits(logic [15:0] fmin, logic [15:0] fmax, logic [15:0] smin,
                            logic [15:0] smax, logic [15:0] tmin, logic [15:0] tmax,
                            logic [15:0] slow);
    write_reg(REG_FWD_MIN, fmin);
    write_reg(REG_FWD_MAX, fmax);
    write_reg(REG_SIDE_MIN, smin);
    write_reg(REG_SIDE_MAX, smax);
    write_reg(REG_TURN_MIN, tmin);
    write_reg(REG_TURN_MAX, tmax);
    write_reg(REG_TURN_SLOWDOWN, slow);
  endtask

  // sends one command; valid stays high when the next item follows at once
  task automatic send_cmd(vel_t f, vel_t s, vel_t t, bit idle_en = 1'b1);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.valid    <= 1'b1;
    cmd_if.cmd_fwd  <= f;
    cmd_if.cmd_side <= s;
    cmd_if.cmd_turn <= t;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    vel_expected.insert(vel_expected.size(), limit_velocity(f, s, t));
  endtask

  task automatic settle();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (vel_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic vel_t rand_cmd();
    case ($urandom_range(0, 5))
      0:       return vel_t'($urandom());
      1:       return vel_t'($urandom_range(0, 8192)) - 16'sd4096;
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return vel_t'($urandom_range(0, 9000)) - 16'sd4500;
    endcase
  endfunction

  task automatic test_extremes();
    vel_t v[8];
    v = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd4096, -16'sd4096, 16'sd1, -16'sd1, 16'sd2896};
    for (int i = 0; i < 8; i++) send_cmd(v[i], v[(i + 3) % 8], v[(i + 5) % 8], 1'b0);
    send_cmd(16'sd0, 16'sd0, 16'sd0);
    send_cmd(16'sd4096, 16'sd4096, 16'sd0);
    // turn at half the slow-down halves the forward cap and rescales the planar command
    send_cmd(16'sd4096, -16'sd2048, 16'sd4096);
    send_cmd(-16'sd4096, 16'sd1000, -16'sd4096);
    settle();
  endtask

  task automatic test_config_corners();
    // widest limits, smallest slow-down
    set_limits(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'd1);
    repeat (6) send_cmd(rand_cmd(), rand_cmd(), rand_cmd());
    settle();
    // zero slow-down acts as one; minimum equal to maximum
    set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (6) send_cmd(rand_cmd(), rand_cmd(), rand_cmd());
    settle();
    set_limits(16'h8000, 16'd0, 16'd0, 16'h7fff, 16'h8000, 16'd0, 16'd0);
    repeat (6) send_cmd(rand_cmd(), rand_cmd(), rand_cmd());
    settle();
    set_limits(16'd0, 16'h7fff, 16'h8000, 16'd0, 16'd0, 16'h7fff, 16'h7fff);
    repeat (6) send_cmd(rand_cmd(), rand_cmd(), rand_cmd());
    settle();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) begin
        set_limits(MIN_RST, 16'(MAX_RST), MIN_RST, 16'(MAX_RST), MIN_RST, 16'(MAX_RST),
                   16'(SLOWDOWN_RST));
      end else begin
        set_limits(16'(-$urandom_range(0, 32768)), 16'($urandom_range(0, 32767)),
                   16'(-$urandom_range(0, 32768)), 16'($urandom_range(0, 32767)),
                   16'(-$urandom_range(0, 32768)), 16'($urandom_range(0, 32767)),
                   16'($urandom_range(0, 32767)));
      end
      sink_stall_en = (ph != 3);
      for (int i = 0; i < 240; i++) send_cmd(rand_cmd(), rand_cmd(), rand_cmd(), ph != 2);
      settle();
    end
    sink_stall_en = 1'b1;
  endtask

  // result ready with random stalls
  initial begin
    int stall;
    vel_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (sink_stall_en && $urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        vel_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      vel_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!vel_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    vel3_t exp_v;
    if (rst_ni && vel_if.valid && vel_if.ready) begin
      if (vel_expected.size() == 0) begin
        $error("unexpected result fwd=%0d side=%0d turn=%0d",
               vel_if.vel_fwd, vel_if.vel_side, vel_if.vel_turn);
        n_errors++;
      end else begin
        exp_v = vel_expected.pop_front();
        if (vel_if.vel_fwd !== exp_v.fwd) begin
          $error("vel_fwd expected %0d actual %0d", exp_v.fwd, vel_if.vel_fwd);
          n_errors++;
        end
        if (vel_if.vel_side !== exp_v.side) begin
          $error("vel_side expected %0d actual %0d", exp_v.side, vel_if.vel_side);
          n_errors++;
        end
        if (vel_if.vel_turn !== exp_v.turn) begin
          $error("vel_turn expected %0d actual %0d", exp_v.turn, vel_if.vel_turn);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cmd_if.valid    = 1'b0;
    cmd_if.cmd_fwd  = '0;
    cmd_if.cmd_side = '0;
    cmd_if.cmd_turn = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    lim_fwd_min  = MIN_RST;
    lim_fwd_max  = MAX_RST;
    lim_side_min = MIN_RST;
    lim_side_max = MAX_RST;
    lim_turn_min = MIN_RST;
    lim_turn_max = MAX_RST;
    lim_slowdown = SLOWDOWN_RST;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_config_corners();
    test_random();
    if (n_errors == 0 && vel_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
